[rtl/bqc_pkg.sv]
// Shared types, constants and helper functions for the biquad cascade.
package bqc_pkg;

  localparam int BQC_MAX_STAGES = 8;
  localparam int BQC_NUM_COEFS  = 6;
  localparam int BQC_FRAC_SHIFT = 28;
  localparam int BQC_ACC_W      = 40;
  localparam int BQC_DEN_W      = 35;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_PRESET = 2'd1,
    OP_COEF   = 2'd2,
    OP_NONE   = 2'd3
  } bqc_op_t;

  typedef enum logic [2:0] {
    COEF_A0 = 3'd0,
    COEF_A1 = 3'd1,
    COEF_A2 = 3'd2,
    COEF_B0 = 3'd3,
    COEF_B1 = 3'd4,
    COEF_B2 = 3'd5
  } bqc_coef_sel_t;

  // Handoff from one section to the next; go is a one-cycle pulse.
  typedef struct packed {
    logic               go;
    logic signed [31:0] y;
    logic               ovf;
    logic               fault;
  } bqc_link_t;

  typedef struct packed {
    logic                         start;
    logic signed [63:0]           num;
    logic signed [BQC_DEN_W-1:0]  den;
  } bqc_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] q;
    logic               ovf;
  } bqc_div_rsp_t;

  // Saturates a wide sum to 32 bits; the top bit of the result flags saturation.
  function automatic logic [32:0] bqc_sat(input logic signed [BQC_ACC_W-1:0] v);
    logic [32:0] r;
    if (v > BQC_ACC_W'(signed'(32'h7FFF_FFFF))) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < BQC_ACC_W'(signed'(32'h8000_0000))) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Floor-shifts a Q8.24 x Q4.28 product back to Q8.24, cut down to the sum width.
  function automatic logic signed [BQC_ACC_W-1:0] bqc_scale(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> BQC_FRAC_SHIFT;
    return s[BQC_ACC_W-1:0];
  endfunction

endpackage

[rtl/bqc_div.sv]
// Shared radix-2 restoring divider for the preset path, one quotient bit per cycle.
module bqc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bqc_pkg::bqc_div_req_t req,
  output bqc_pkg::bqc_div_rsp_t rsp
);
  import bqc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [BQC_DEN_W-1:0] rem_r, rem_nxt;
  logic [63:0]          quo_r, quo_nxt;
  logic [BQC_DEN_W-2:0] dmag_r, dmag_nxt;
  logic                 neg_r, neg_nxt;
  bqc_div_rsp_t         rsp_r, rsp_nxt;

  logic [BQC_DEN_W-1:0] rem_sh;
  logic [BQC_DEN_W-1:0] rem_sub;
  logic                 fits;
  logic [63:0]          qfin;
  logic                 qovf;

  always_comb begin
    rem_sh  = {rem_r[BQC_DEN_W-2:0], quo_r[63]};
    rem_sub = rem_sh - {1'b0, dmag_r};
    fits    = (rem_sh >= {1'b0, dmag_r});
    qfin    = {quo_r[62:0], fits};
    qovf    = neg_r ? (qfin > 64'h0000_0000_8000_0000) : (qfin > 64'h0000_0000_7FFF_FFFF);

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    rsp_nxt  = '0;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num[63] ? 64'(-req.num) : req.num;
      dmag_nxt = req.den[BQC_DEN_W-1] ? (BQC_DEN_W-1)'(-req.den)
                                      : req.den[BQC_DEN_W-2:0];
      neg_nxt  = req.num[63] ^ req.den[BQC_DEN_W-1];
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub : rem_sh;
      quo_nxt = qfin;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt     = 1'b0;
        rsp_nxt.done = 1'b1;
        rsp_nxt.ovf  = qovf;
        if (qovf) begin
          rsp_nxt.q = neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          rsp_nxt.q = neg_r ? 32'(-qfin) : qfin[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rsp_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rsp_r  <= rsp_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  assign rsp = rsp_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_r.done |=> !rsp_r.done) else $error("divider done held over two cycles");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_r.done |-> !busy_r) else $error("divider done while still busy");
`endif

endmodule

[rtl/bqc_cell.sv]
// One second-order section: its coefficients, delay pair and a sequenced multiply-accumulate.
module bqc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  enable,
  input  bqc_pkg::bqc_op_t      op,
  input  bqc_pkg::bqc_link_t    link_i,
  output bqc_pkg::bqc_link_t    link_o,
  input  logic                  coef_we,
  input  logic [2:0]            coef_sel,
  input  logic signed [31:0]    coef_val,
  output bqc_pkg::bqc_div_req_t div_req,
  input  bqc_pkg::bqc_div_rsp_t div_rsp
);
  import bqc_pkg::*;

  logic signed [31:0]          coef_r [BQC_NUM_COEFS];
  logic signed [31:0]          m0_r, m0_nxt, m1_r, m1_nxt;
  logic signed [63:0]          prod_r, prod_nxt;
  logic signed [BQC_ACC_W-1:0] acc_r, acc_nxt;
  logic signed [31:0]          w_r, w_nxt;
  logic signed [31:0]          x_r, x_nxt;
  logic                        busy_r, busy_nxt;
  logic                        dwait_r, dwait_nxt;
  logic [2:0]                  ph_r, ph_nxt;
  bqc_link_t                   out_r, out_nxt;

  logic signed [31:0]          opa, opb;
  logic signed [BQC_ACC_W-1:0] sh;
  logic signed [BQC_DEN_W-1:0] den;
  logic [32:0]                 sat;
  logic                        preset;

  assign preset = (op == OP_PRESET);
  assign sh     = bqc_scale(prod_r);
  assign den    = BQC_DEN_W'(coef_r[COEF_A1]) + BQC_DEN_W'(coef_r[COEF_A2])
                + (BQC_DEN_W'(1) <<< BQC_FRAC_SHIFT);

  always_comb begin
    case (ph_r)
      3'd0:    begin opa = x_r; opb = coef_r[COEF_A0]; end
      3'd1:    begin opa = m0_r; opb = coef_r[COEF_A1]; end
      3'd2:    begin opa = m1_r; opb = coef_r[COEF_A2]; end
      3'd4:    begin opa = w_r; opb = coef_r[COEF_B0]; end
      3'd5:    begin opa = preset ? w_r : m0_r; opb = coef_r[COEF_B1]; end
      3'd6:    begin opa = preset ? w_r : m1_r; opb = coef_r[COEF_B2]; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    m0_nxt    = m0_r;
    m1_nxt    = m1_r;
    prod_nxt  = 64'(opa) * 64'(opb);
    acc_nxt   = acc_r;
    w_nxt     = w_r;
    x_nxt     = x_r;
    busy_nxt  = busy_r;
    dwait_nxt = dwait_r;
    ph_nxt    = ph_r;
    out_nxt   = out_r;
    out_nxt.go = 1'b0;
    div_req   = '0;
    sat       = '0;

    if (link_i.go && enable) begin
      busy_nxt      = 1'b1;
      ph_nxt        = 3'd0;
      x_nxt         = link_i.y;
      out_nxt.ovf   = link_i.ovf;
      out_nxt.fault = link_i.fault;
    end else if (busy_r && dwait_r) begin
      if (div_rsp.done) begin
        dwait_nxt   = 1'b0;
        w_nxt       = div_rsp.q;
        out_nxt.ovf = out_r.ovf | div_rsp.ovf;
        ph_nxt      = 3'd4;
      end
    end else if (busy_r) begin
      ph_nxt = ph_r + 3'd1;
      case (ph_r)
        3'd1: begin
          if (preset) begin
            if (den == '0) begin
              out_nxt.fault = 1'b1;
              w_nxt         = '0;
              ph_nxt        = 3'd4;
            end else begin
              div_req.start = 1'b1;
              div_req.num   = prod_r;
              div_req.den   = den;
              dwait_nxt     = 1'b1;
              ph_nxt        = ph_r;
            end
          end else begin
            acc_nxt = sh;
          end
        end
        3'd2: acc_nxt = acc_r - sh;
        3'd3: begin
          sat         = bqc_sat(acc_r - sh);
          w_nxt       = sat[31:0];
          out_nxt.ovf = out_r.ovf | sat[32];
        end
        3'd5: acc_nxt = sh;
        3'd6: acc_nxt = acc_r + sh;
        3'd7: begin
          sat         = bqc_sat(acc_r + sh);
          out_nxt.y   = sat[31:0];
          out_nxt.ovf = out_r.ovf | sat[32];
          out_nxt.go  = 1'b1;
          busy_nxt    = 1'b0;
          m0_nxt      = w_r;
          m1_nxt      = preset ? w_r : m0_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BQC_NUM_COEFS; i++) coef_r[i] <= '0;
      m0_r    <= '0;
      m1_r    <= '0;
      busy_r  <= 1'b0;
      dwait_r <= 1'b0;
      out_r   <= '0;
    end else begin
      if (coef_we) coef_r[coef_sel] <= coef_val;
      m0_r    <= m0_nxt;
      m1_r    <= m1_nxt;
      busy_r  <= busy_nxt;
      dwait_r <= dwait_nxt;
      out_r   <= out_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    w_r    <= w_nxt;
    x_r    <= x_nxt;
    ph_r   <= ph_nxt;
  end

  assign link_o = out_r;

`ifndef SYNTHESIS
  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dwait_r |-> busy_r) else $error("divider wait outside a busy section");
  a_go_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.go |-> !busy_r) else $error("section handed off while still busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !(link_i.go && enable)) else $error("section restarted while busy");
`endif

endmodule

[rtl/biquad_cascade_iir_filter_unit.sv]
// Top level of the cascaded biquad filter: stream ports, control and the chain of sections.
// A filter item runs through the N active sections in turn, N the active section count; a
//   preset also waits on the shared divider in each section with a nonzero denominator and
//   skips the divide for a zero one. Coefficient writes, unused opcodes and N = 0 skip the chain.
// Throughput: one item at a time; in_tready returns the cycle after the result is loaded.
// Reset (rst_n low, synchronous) clears coefficients, delay states and the stage count.
module biquad_cascade_iir_filter_unit #(
  parameter int MAX_STAGES = bqc_pkg::BQC_MAX_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sample_in [31:0], coef_stage [34:32], coef_select [37:35], coef_value [69:38], zero pad
  input  logic [71:0] in_tdata,
  // opcode [1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sample_out [31:0]
  output logic [31:0] out_tdata,
  // overflow [0], divide_fault [1]
  output logic [1:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);
  import bqc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [3:0]         stage_cnt_r;
  logic [5:0]         n_act;
  logic               start_r, start_nxt;
  logic signed [31:0] x_r, x_nxt;
  bqc_op_t            op_r, op_nxt;
  logic [31:0]        res_y_r, res_y_nxt;
  logic [1:0]         res_f_r, res_f_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_y_r, out_y_nxt;
  logic [1:0]         out_f_r, out_f_nxt;

  bqc_link_t          link [MAX_STAGES+1];
  bqc_div_req_t       cell_req [MAX_STAGES];
  bqc_div_req_t       div_req;
  bqc_div_rsp_t       div_rsp;
  logic [MAX_STAGES-1:0] done_vec;
  logic               fin;
  bqc_link_t          fin_link;

  logic               accept;
  bqc_op_t            in_op;
  logic [2:0]         in_stage, in_sel;

  assign in_op    = bqc_op_t'(in_tuser);
  assign in_stage = in_tdata[34:32];
  assign in_sel   = in_tdata[37:35];
  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Stage counts above the build maximum act as the maximum.
  assign n_act = ({2'b00, stage_cnt_r} > 6'(MAX_STAGES)) ? 6'(MAX_STAGES)
                                                         : {2'b00, stage_cnt_r};

  // The first link carries the accepted sample into section zero.
  always_comb begin
    link[0]       = '0;
    link[0].go    = start_r;
    link[0].y     = x_r;
  end

  for (genvar g = 0; g < MAX_STAGES; g++) begin : g_cell
    logic we;
    assign we = accept && (in_op == OP_COEF) && (6'(in_stage) == 6'(g))
             && (in_sel < 3'(BQC_NUM_COEFS));
    bqc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .enable   (6'(g) < n_act),
      .op       (op_r),
      .link_i   (link[g]),
      .link_o   (link[g+1]),
      .coef_we  (we),
      .coef_sel (in_sel),
      .coef_val (signed'(in_tdata[69:38])),
      .div_req  (cell_req[g]),
      .div_rsp  (div_rsp)
    );
    // Only the last active section ends the item.
    assign done_vec[g] = link[g+1].go && (6'(g + 1) == n_act);
  end

  // Only one section is busy at a time, so the requests simply merge.
  always_comb begin
    div_req  = '0;
    fin_link = '0;
    for (int i = 0; i < MAX_STAGES; i++) begin
      div_req = div_req | cell_req[i];
      if (done_vec[i]) fin_link = link[i+1];
    end
  end
  assign fin = |done_vec;

  bqc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Control: accept in idle, run the chain, then park the result until the output
  // register is free. The output register lets a finished result wait for its
  // transfer while the next item is already accepted.
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    x_nxt         = x_r;
    op_nxt        = op_r;
    res_y_nxt     = res_y_r;
    res_f_nxt     = res_f_r;
    out_valid_nxt = out_valid_r;
    out_y_nxt     = out_y_r;
    out_f_nxt     = out_f_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt  = signed'(in_tdata[31:0]);
          op_nxt = in_op;
          if (((in_op == OP_FILTER) || (in_op == OP_PRESET)) && (n_act != '0)) begin
            start_nxt = 1'b1;
            state_nxt = ST_RUN;
          end else begin
            // Pass-through for an empty cascade, zero for the other opcodes.
            res_y_nxt = ((in_op == OP_FILTER) || (in_op == OP_PRESET))
                        ? in_tdata[31:0] : '0;
            res_f_nxt = '0;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_RUN: begin
        if (fin) begin
          res_y_nxt = fin_link.y;
          res_f_nxt = {fin_link.fault, fin_link.ovf};
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = res_y_r;
          out_f_nxt     = res_f_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      stage_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) stage_cnt_r <= cfg_wdata;
    end
    x_r     <= x_nxt;
    op_r    <= op_nxt;
    res_y_r <= res_y_nxt;
    res_f_r <= res_f_nxt;
    out_y_r <= out_y_nxt;
    out_f_r <= out_f_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_y_r;
  assign out_tuser  = out_f_r;

`ifndef SYNTHESIS
  a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(done_vec)) else $error("more than one section finished at once");
  a_finish_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (state_r == ST_RUN)) else $error("section finished outside a run");
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("input ready right after a transfer");
`endif

endmodule

[tb/sv/biquad_cascade_iir_filter_unit_test.sv]
// Self-checking testbench for the cascaded biquad filter unit with its own bit-exact predictor.
module biquad_cascade_iir_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bqc_pkg::*;

  // A stream of cycles without any transfer longer than this ends the run. The slowest
  // item is a preset through eight sections, and the receiver may stall on top of that.
  localparam int STALL_LIMIT = 20000;
  localparam longint Q28_UNITY = 64'sd268435456;
  // Bounds that keep random sections stable: |a1|, |a2| below 0.4 and |b| at most 0.5.
  localparam int POLE_SPAN = 107374182;
  localparam int ZERO_SPAN = 134217728;

  typedef struct {
    logic signed [31:0] smp;
    logic               ovf;
    logic               fault;
  } filt_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;

  // The predictor keeps its own copy of the coefficient table, the delay pairs and the
  // stage count register.
  logic signed [31:0] coef_mem [48];
  logic signed [31:0] delay_mem [16];
  logic [3:0]         stage_reg;
  logic               sat_hit;

  filt_result_t result_q[$];
  int mismatch_count;
  int stall_cycles;
  int tx_idle;
  int rx_idle;

  biquad_cascade_iir_filter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // A Q8.24 value times a Q4.28 coefficient, brought back to Q8.24 with floor rounding.
  function automatic longint scale_prod(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 28;
  endfunction

  // Clamps a sum to 32 bits and remembers that saturation happened during this item.
  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      sat_hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat_hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Applies one item to the predictor state and returns the result the block must give.
  function automatic filt_result_t run_item(bqc_op_t op, logic signed [31:0] x,
                                            logic [2:0] cs, logic [2:0] sel,
                                            logic signed [31:0] cv);
    filt_result_t r;
    int n;
    int b;
    longint m0;
    longint m1;
    longint den;
    longint num;
    logic signed [31:0] y;
    logic signed [31:0] w;
    logic signed [31:0] z;
    sat_hit = 1'b0;
    r.fault = 1'b0;
    y = '0;
    // Stage counts above the maximum behave as the maximum.
    n = (stage_reg > 4'd8) ? 8 : int'(stage_reg);
    case (op)
      OP_FILTER: begin
        y = x;
        for (int s = 0; s < n; s++) begin
          b = s * 6;
          m0 = delay_mem[2*s];
          m1 = delay_mem[2*s+1];
          w = clamp32(scale_prod(y, coef_mem[b+int'(COEF_A0)])
                      - scale_prod(m0, coef_mem[b+int'(COEF_A1)])
                      - scale_prod(m1, coef_mem[b+int'(COEF_A2)]));
          y = clamp32(scale_prod(w, coef_mem[b+int'(COEF_B0)])
                      + scale_prod(m0, coef_mem[b+int'(COEF_B1)])
                      + scale_prod(m1, coef_mem[b+int'(COEF_B2)]));
          delay_mem[2*s+1] = m0[31:0];
          delay_mem[2*s]   = w;
        end
      end
      OP_PRESET: begin
        y = x;
        for (int s = 0; s < n; s++) begin
          b = s * 6;
          den = Q28_UNITY + longint'(coef_mem[b+int'(COEF_A1)])
                + longint'(coef_mem[b+int'(COEF_A2)]);
          if (den == 0) begin
            // A zero denominator zeroes the section and passes zero onward.
            r.fault = 1'b1;
            z = '0;
          end else begin
            num = longint'(y) * longint'(coef_mem[b+int'(COEF_A0)]);
            z = clamp32(num / den);
          end
          delay_mem[2*s]   = z;
          delay_mem[2*s+1] = z;
          y = clamp32(scale_prod(z, coef_mem[b+int'(COEF_B0)])
                      + scale_prod(z, coef_mem[b+int'(COEF_B1)])
                      + scale_prod(z, coef_mem[b+int'(COEF_B2)]));
        end
      end
      OP_COEF: begin
        // Selects six and seven name no coefficient and are dropped.
        if (sel <= COEF_B2) coef_mem[int'(cs)*6 + int'(sel)] = cv;
      end
      default: begin
      end
    endcase
    r.smp = y;
    r.ovf = sat_hit;
    return r;
  endfunction

  // Output side: random back-pressure, and every result transfer is compared in order.
  // The same process guards against a hang by counting cycles without any transfer.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: sample %h flags %b", out_tdata, out_tuser);
      end else begin
        if (out_tdata !== result_q[0].smp || out_tuser[0] !== result_q[0].ovf ||
            out_tuser[1] !== result_q[0].fault) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected sample %h ovf %b fault %b, got sample %h ovf %b fault %b",
                     result_q[0].smp, result_q[0].ovf, result_q[0].fault,
                     out_tdata, out_tuser[0], out_tuser[1]);
        end
        void'(result_q.pop_front());
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offers one item, with random idle cycles ahead of it, and records its prediction once
  // the transfer has happened. Valid is left high so that back-to-back items stay tight.
  task automatic send_item(bqc_op_t op, logic signed [31:0] x, logic [2:0] cs,
                           logic [2:0] sel, logic signed [31:0] cv);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, cv, sel, cs, x};
    do @(posedge clk); while (!in_tready);
    result_q.push_back(run_item(op, x, cs, sel, cv));
  endtask

  task automatic write_coef(int stage, bqc_coef_sel_t sel, logic signed [31:0] val);
    send_item(OP_COEF, $urandom, stage[2:0], sel, val);
  endtask

  // Waits until every expected result has arrived, then a few more cycles of quiet.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the stage count; only called while the block is idle.
  task automatic set_stage_count(logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stage_reg = val;
  endtask

  function automatic logic signed [31:0] rand_coef(bqc_coef_sel_t sel);
    // A few coefficients are completely random to drive saturation and odd denominators.
    if ($urandom_range(9) == 0) return $urandom;
    case (sel)
      COEF_A0: return 32'sd268435456 + ($urandom_range(2*ZERO_SPAN) - ZERO_SPAN);
      COEF_A1, COEF_A2: return $urandom_range(2*POLE_SPAN) - POLE_SPAN;
      default: return $urandom_range(2*ZERO_SPAN) - ZERO_SPAN;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_sample();
    if ($urandom_range(1) == 0) return $urandom;
    return $urandom_range(32'h0200_0000) - 32'h0100_0000;
  endfunction

  // Extremes of the fields, every opcode, dropped writes, zero denominators and saturation.
  task automatic test_directed();
    // With no active section samples pass straight through.
    send_item(OP_FILTER, 32'sh7FFF_FFFF, 3'd0, 3'd0, '0);
    send_item(OP_FILTER, 32'sh8000_0000, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(OP_NONE, 32'h1234_5678, 3'd7, 3'd7, 32'h8000_0000);
    send_item(OP_COEF, 32'hFFFF_FFFF, 3'd3, 3'd6, 32'h7FFF_FFFF);
    send_item(OP_COEF, 32'h0, 3'd5, 3'd7, 32'hFFFF_FFFF);
    // Section 0 with a1 = -1 and a2 = 0 has a zero steady-state denominator.
    write_coef(0, COEF_A0, 32'sd268435456);
    write_coef(0, COEF_A1, -32'sd268435456);
    write_coef(0, COEF_A2, 32'sd0);
    write_coef(0, COEF_B0, 32'sh7FFF_FFFF);
    write_coef(0, COEF_B1, 32'sh8000_0000);
    write_coef(0, COEF_B2, 32'sd268435456);
    write_coef(7, COEF_B2, 32'sh8000_0000);
    drain_results();
    set_stage_count(4'd1);
    send_item(OP_PRESET, 32'sh0100_0000, 3'd0, 3'd0, '0);
    send_item(OP_FILTER, 32'sh7FFF_FFFF, 3'd0, 3'd0, '0);
    send_item(OP_FILTER, 32'sh8000_0000, 3'd0, 3'd0, '0);
    // A tiny denominator makes the preset quotient saturate.
    write_coef(0, COEF_A1, -32'sd268435455);
    send_item(OP_PRESET, 32'sh7FFF_FFFF, 3'd0, 3'd0, '0);
    write_coef(0, COEF_A0, 32'sh7FFF_FFFF);
    write_coef(0, COEF_A1, 32'sh8000_0001);
    send_item(OP_PRESET, 32'sh8000_0000, 3'd0, 3'd0, '0);
    send_item(OP_FILTER, 32'sh8000_0000, 3'd0, 3'd0, '0);
    drain_results();
  endtask

  // Loads fresh, mostly stable coefficients into all eight sections for random traffic.
  task automatic load_all_sections();
    for (int s = 0; s < 8; s++)
      for (int c = 0; c <= int'(COEF_B2); c++)
        write_coef(s, bqc_coef_sel_t'(c), rand_coef(bqc_coef_sel_t'(c)));
  endtask

  // Mostly filtering of random samples, with presets, coefficient updates, the unused
  // opcode and now and then a deliberate zero denominator mixed in.
  task automatic test_random(int send_idle, int recv_idle, int count);
    int pick;
    logic [2:0] cs;
    logic [2:0] sel;
    tx_idle = send_idle;
    rx_idle = recv_idle;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        drain_results();
        if (i == 0) set_stage_count(4'd15);
        else if (i == 100) set_stage_count(4'd0);
        else set_stage_count(4'($urandom_range(15)));
      end
      pick = $urandom_range(99);
      cs   = 3'($urandom_range(7));
      sel  = 3'($urandom_range(7));
      if (pick < 72) begin
        send_item(OP_FILTER, rand_sample(), cs, sel, $urandom);
      end else if (pick < 80) begin
        send_item(OP_PRESET, rand_sample(), cs, sel, $urandom);
      end else if (pick < 95) begin
        send_item(OP_COEF, $urandom, cs, sel,
                  (sel <= COEF_B2) ? rand_coef(bqc_coef_sel_t'(sel)) : $urandom);
      end else if (pick < 97) begin
        write_coef(int'(cs), COEF_A1, -32'sd268435456);
        write_coef(int'(cs), COEF_A2, 32'sd0);
      end else begin
        send_item(OP_NONE, $urandom, cs, sel, $urandom);
      end
    end
    drain_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    tx_idle        = 0;
    rx_idle        = 0;
    stage_reg      = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (delay_mem[i]) delay_mem[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    load_all_sections();
    test_random(28, 69, 300);
    load_all_sections();
    test_random(69, 28, 300);
    load_all_sections();
    test_random(0, 0, 300);
    drain_results();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
